// ===== src/ocg_pkg.sv =====
// Package with the shared types and constants of the finger overcurrent grasp guard.
`default_nettype none

package ocg_pkg;

    // Operation codes of a request.
    localparam logic [1:0] OP_TARGET = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // Event codes of a result.
    localparam logic [1:0] EV_NONE        = 2'd0;
    localparam logic [1:0] EV_OVERCURRENT = 2'd1;
    localparam logic [1:0] EV_CONTACT     = 2'd2;
    localparam logic [1:0] EV_UNLOCK      = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_OVERCURRENT_LIMIT = 3'd0;
    localparam logic [2:0] CFG_CONTACT_THRESHOLD = 3'd1;
    localparam logic [2:0] CFG_SOFT_GRASP_ENABLE = 3'd2;
    localparam logic [2:0] CFG_RELEASE_CURRENT   = 3'd3;
    localparam logic [2:0] CFG_RELEASE_TIME_MS   = 3'd4;

    // Configuration reset values.
    localparam logic [14:0] RST_OVERCURRENT_LIMIT = 15'd1500;
    localparam logic [14:0] RST_CONTACT_THRESHOLD = 15'd650;
    localparam logic        RST_SOFT_GRASP_ENABLE = 1'b1;
    localparam logic [14:0] RST_RELEASE_CURRENT   = 15'd500;
    localparam logic [15:0] RST_RELEASE_TIME_MS   = 16'd1000;

    // Largest angle; also the reset value of the target and held angles.
    localparam logic [9:0] ANGLE_MAX = 10'd1000;

    // Depth of the queues between the parts of the block.
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [14:0] overcurrent_limit;
        logic [14:0] contact_threshold;
        logic        soft_grasp_enable;
        logic [14:0] release_current;
        logic [15:0] release_time_ms;
    } t_cfg;

    // A classified request on its way from the front end to the back end.
    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  finger;
        logic        in_range;
        logic [9:0]  angle;
        logic        oc_hit;
        logic        ct_hit;
        logic        rc_low;
        logic [31:0] timestamp;
    } t_cmd;

    typedef struct packed {
        logic [2:0] finger;
        logic [9:0] held_angle;
        logic       locked;
        logic       contact;
        logic [1:0] event_res;
    } t_res;

endpackage

`default_nettype wire

// ===== src/ocg_fifo.sv =====
// Small first-in first-out queue built from registers.
`default_nettype none

module ocg_fifo
    import ocg_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_PTR = AW'(QUEUE_DEPTH - 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == FULL_COUNT);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== src/ocg_front.sv =====
// Front end: classifies an incoming request against the configuration.
`default_nettype none

module ocg_front
    import ocg_pkg::*;
#(
    parameter int FINGER_COUNT = 6
) (
    input  wire t_cfg               i_cfg,
    input  wire logic        [1:0]  i_op,
    input  wire logic        [2:0]  i_finger,
    input  wire logic        [9:0]  i_target_angle,
    input  wire logic signed [15:0] i_motor_current,
    input  wire logic        [9:0]  i_measured_angle,
    input  wire logic        [31:0] i_timestamp_ms,
    output t_cmd                    o_cmd
);

    localparam logic [4:0] FINGER_LIMIT = 5'(FINGER_COUNT);

    logic [9:0] raw_angle;

    // The angle that matters depends on the operation; both saturate at the maximum.
    assign raw_angle = (i_op == OP_TARGET) ? i_target_angle : i_measured_angle;

    always_comb begin
        o_cmd           = '0;
        o_cmd.op        = i_op;
        o_cmd.finger    = i_finger;
        o_cmd.in_range  = ({2'b00, i_finger} < FINGER_LIMIT);
        o_cmd.angle     = (raw_angle > ANGLE_MAX) ? ANGLE_MAX : raw_angle;
        o_cmd.oc_hit    = i_motor_current > $signed({1'b0, i_cfg.overcurrent_limit});
        o_cmd.ct_hit    = i_cfg.soft_grasp_enable &&
                          (i_motor_current > $signed({1'b0, i_cfg.contact_threshold}));
        o_cmd.rc_low    = i_motor_current < $signed({1'b0, i_cfg.release_current});
        o_cmd.timestamp = i_timestamp_ms;
    end

endmodule

`default_nettype wire

// ===== src/ocg_back.sv =====
// Back end: holds the per-finger state and carries out one classified request a cycle unless the result queue is full.
`default_nettype none

module ocg_back
    import ocg_pkg::*;
#(
    parameter int FINGER_COUNT = 6
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [15:0] i_release_time_ms,
    input  wire t_cmd        i_cmd,
    input  wire logic        i_cmd_empty,
    output logic             o_cmd_pop,
    input  wire logic        i_res_full,
    output logic             o_res_push,
    output t_res             o_res
);

    localparam int IW = (FINGER_COUNT > 1) ? $clog2(FINGER_COUNT) : 1;

    logic [9:0]  r_target  [FINGER_COUNT];
    logic [9:0]  r_held    [FINGER_COUNT];
    logic        r_lock    [FINGER_COUNT];
    logic        r_contact [FINGER_COUNT];
    logic        r_timing  [FINGER_COUNT];
    logic [31:0] r_start   [FINGER_COUNT];

    logic [IW-1:0] idx;
    logic          fire;
    logic          write_en;
    logic [9:0]    cur_target;
    logic [9:0]    cur_held;
    logic          cur_lock;
    logic          cur_contact;
    logic          cur_timing;
    logic [31:0]   cur_start;
    logic [31:0]   elapsed;
    logic [9:0]    n_target;
    logic [9:0]    n_held;
    logic          n_lock;
    logic          n_contact;
    logic          n_timing;
    logic [31:0]   n_start;
    logic [1:0]    ev;

    assign idx        = IW'(i_cmd.finger);
    assign fire       = !i_cmd_empty && !i_res_full;
    assign write_en   = fire && i_cmd.in_range;
    assign o_cmd_pop  = fire;
    assign o_res_push = fire;

    assign cur_target  = r_target[idx];
    assign cur_held    = r_held[idx];
    assign cur_lock    = r_lock[idx];
    assign cur_contact = r_contact[idx];
    assign cur_timing  = r_timing[idx];
    assign cur_start   = r_start[idx];
    assign elapsed     = i_cmd.timestamp - cur_start;

    always_comb begin
        n_target  = cur_target;
        n_held    = cur_held;
        n_lock    = cur_lock;
        n_contact = cur_contact;
        n_timing  = cur_timing;
        n_start   = cur_start;
        ev        = EV_NONE;
        case (i_cmd.op)
            OP_TARGET: begin
                if (!cur_lock) begin
                    n_target = i_cmd.angle;
                end
                if (i_cmd.angle > cur_held) begin
                    n_contact = 1'b0;
                end
            end
            OP_SAMPLE: begin
                if (i_cmd.oc_hit && !cur_lock) begin
                    n_lock = 1'b1;
                    n_held = i_cmd.angle;
                    ev     = EV_OVERCURRENT;
                end
                if (i_cmd.ct_hit && !cur_contact && !n_lock) begin
                    n_contact = 1'b1;
                    n_held    = i_cmd.angle;
                    ev        = EV_CONTACT;
                end
                if (n_lock) begin
                    if (i_cmd.rc_low) begin
                        // A freshly started timer has zero elapsed time and cannot expire.
                        if (!cur_timing) begin
                            n_timing = 1'b1;
                            n_start  = i_cmd.timestamp;
                        end else if (elapsed > {16'h0000, i_release_time_ms}) begin
                            n_lock   = 1'b0;
                            n_timing = 1'b0;
                            n_start  = '0;
                            ev       = EV_UNLOCK;
                        end
                    end else begin
                        n_timing = 1'b0;
                        n_start  = '0;
                    end
                end
            end
            OP_TICK: begin
                if (!cur_lock && !cur_contact) begin
                    n_held = cur_target;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_res        = '0;
        o_res.finger = i_cmd.finger;
        if (i_cmd.in_range) begin
            o_res.held_angle = n_held;
            o_res.locked     = n_lock;
            o_res.contact    = n_contact;
            o_res.event_res  = ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FINGER_COUNT; i++) begin
                r_target[i]  <= ANGLE_MAX;
                r_held[i]    <= ANGLE_MAX;
                r_lock[i]    <= 1'b0;
                r_contact[i] <= 1'b0;
                r_timing[i]  <= 1'b0;
            end
        end else if (write_en) begin
            r_target[idx]  <= n_target;
            r_held[idx]    <= n_held;
            r_lock[idx]    <= n_lock;
            r_contact[idx] <= n_contact;
            r_timing[idx]  <= n_timing;
        end
    end

    // The start time is only read while its timing flag is set, so it needs no reset.
    always_ff @(posedge i_clk) begin
        if (write_en) begin
            r_start[idx] <= n_start;
        end
    end

endmodule

`default_nettype wire

// ===== src/finger_overcurrent_grasp_guard.sv =====
// Top level of the per-finger overcurrent and soft-grasp guard.
// A request passes the command queue and the back end; its result shows with empty low.
// Throughput: one request per cycle unless the result queue is full, set by the back end's
// read-modify-write of a finger's state; the two-entry queues let either side stall on its own.
// Reset is synchronous and active low: configuration returns to its defaults, every finger
// gets target and held angle 1000 with no locks, and both queues are emptied.
`default_nettype none

module finger_overcurrent_grasp_guard
    import ocg_pkg::*;
#(
    parameter int FINGER_COUNT = 6
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Request side.
    input  wire logic               push,
    output logic                    full,
    input  wire logic        [1:0]  i_op,
    input  wire logic        [2:0]  i_finger,
    input  wire logic        [9:0]  i_target_angle,
    input  wire logic signed [15:0] i_motor_current,
    input  wire logic        [9:0]  i_measured_angle,
    input  wire logic        [31:0] i_timestamp_ms,
    // Result side.
    output logic                    empty,
    input  wire logic               pop,
    output logic             [2:0]  o_finger_out,
    output logic             [9:0]  o_held_angle,
    output logic                    o_overcurrent_locked,
    output logic                    o_contact_held,
    output logic             [1:0]  o_event_res,
    // Configuration write channel.
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic        [2:0]  i_cfg_index,
    input  wire logic        [15:0] i_cfg_data
);

    t_cfg r_cfg;
    t_cmd front_cmd;
    t_cmd back_cmd;
    t_res back_res;
    t_res out_res;
    logic cmd_empty;
    logic cmd_pop;
    logic res_full;
    logic res_push;

    // Always accepted; the user must write configuration only while idle (the block does not enforce it).
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.overcurrent_limit <= RST_OVERCURRENT_LIMIT;
            r_cfg.contact_threshold <= RST_CONTACT_THRESHOLD;
            r_cfg.soft_grasp_enable <= RST_SOFT_GRASP_ENABLE;
            r_cfg.release_current   <= RST_RELEASE_CURRENT;
            r_cfg.release_time_ms   <= RST_RELEASE_TIME_MS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_OVERCURRENT_LIMIT: r_cfg.overcurrent_limit <= i_cfg_data[14:0];
                CFG_CONTACT_THRESHOLD: r_cfg.contact_threshold <= i_cfg_data[14:0];
                CFG_SOFT_GRASP_ENABLE: r_cfg.soft_grasp_enable <= i_cfg_data[0];
                CFG_RELEASE_CURRENT:   r_cfg.release_current   <= i_cfg_data[14:0];
                CFG_RELEASE_TIME_MS:   r_cfg.release_time_ms   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // The front end turns the raw request into saturated angles and threshold flags,
    // so the back end works with single bits instead of wide signed compares.
    ocg_front #(
        .FINGER_COUNT(FINGER_COUNT)
    ) u_front (
        .i_cfg            (r_cfg),
        .i_op             (i_op),
        .i_finger         (i_finger),
        .i_target_angle   (i_target_angle),
        .i_motor_current  (i_motor_current),
        .i_measured_angle (i_measured_angle),
        .i_timestamp_ms   (i_timestamp_ms),
        .o_cmd            (front_cmd)
    );

    // Classified requests wait here until the back end can take them.
    ocg_fifo #(
        .WIDTH($bits(t_cmd))
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_data  (back_cmd),
        .o_empty (cmd_empty)
    );

    // The back end owns all per-finger state and produces exactly one result per request.
    ocg_back #(
        .FINGER_COUNT(FINGER_COUNT)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_release_time_ms (r_cfg.release_time_ms),
        .i_cmd             (back_cmd),
        .i_cmd_empty       (cmd_empty),
        .o_cmd_pop         (cmd_pop),
        .i_res_full        (res_full),
        .o_res_push        (res_push),
        .o_res             (back_res)
    );

    // Results wait here for the consumer, so a stalled consumer does not stop the back end
    // until this queue fills.
    ocg_fifo #(
        .WIDTH($bits(t_res))
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (out_res),
        .o_empty (empty)
    );

    assign o_finger_out         = out_res.finger;
    assign o_held_angle         = out_res.held_angle;
    assign o_overcurrent_locked = out_res.locked;
    assign o_contact_held       = out_res.contact;
    assign o_event_res          = out_res.event_res;

endmodule

`default_nettype wire

// ===== src/ocg_checker.sv =====
// Port-level checker for the finger overcurrent grasp guard, and its bind statement.
`default_nettype none

module ocg_port_checker
    import ocg_pkg::*;
#(
    parameter int FINGER_COUNT = 6
) (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [2:0] o_finger_out,
    input wire logic [9:0] o_held_angle,
    input wire logic       o_overcurrent_locked,
    input wire logic       o_contact_held,
    input wire logic [1:0] o_event_res
);

    localparam logic [4:0] FINGER_LIMIT = 5'(FINGER_COUNT);

    // A result of a finger that does not exist reports nothing but its index.
    a_unknown_finger_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && ({2'b00, o_finger_out} >= FINGER_LIMIT)) |->
        (o_held_angle == '0 && !o_overcurrent_locked && !o_contact_held &&
         o_event_res == EV_NONE))
        else $error("unknown finger result carries state");

    // Each lock event matches the flags reported with it.
    a_event_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |->
        ((o_event_res != EV_OVERCURRENT || o_overcurrent_locked) &&
         (o_event_res != EV_CONTACT || (o_contact_held && !o_overcurrent_locked)) &&
         (o_event_res != EV_UNLOCK || !o_overcurrent_locked)))
        else $error("event code disagrees with lock flags");

    // The held angle never exceeds the mechanical maximum.
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_held_angle <= ANGLE_MAX))
        else $error("held angle above maximum");

    // A result that is not taken stays put.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=>
        (!empty && $stable(o_finger_out) && $stable(o_held_angle) &&
         $stable(o_overcurrent_locked) && $stable(o_contact_held) && $stable(o_event_res)))
        else $error("waiting result changed or vanished");

endmodule

bind finger_overcurrent_grasp_guard ocg_port_checker #(
    .FINGER_COUNT(FINGER_COUNT)
) u_ocg_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .empty                (empty),
    .pop                  (pop),
    .o_finger_out         (o_finger_out),
    .o_held_angle         (o_held_angle),
    .o_overcurrent_locked (o_overcurrent_locked),
    .o_contact_held       (o_contact_held),
    .o_event_res          (o_event_res)
);

`default_nettype wire

// ===== tb/ocg_checker.sv =====
// Checker that predicts and compares every result of the finger overcurrent grasp guard.
`timescale 1ns / 100ps

module ocg_checker
    import ocg_pkg::*;
#(
    parameter int FINGERS = 6
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire logic               i_full,
    input  wire logic        [1:0]  i_op,
    input  wire logic        [2:0]  i_finger,
    input  wire logic        [9:0]  i_target_angle,
    input  wire logic signed [15:0] i_motor_current,
    input  wire logic        [9:0]  i_measured_angle,
    input  wire logic        [31:0] i_timestamp_ms,
    input  wire logic               i_empty,
    input  wire logic               i_pop,
    input  wire logic        [2:0]  i_finger_out,
    input  wire logic        [9:0]  i_held_angle,
    input  wire logic               i_overcurrent_locked,
    input  wire logic               i_contact_held,
    input  wire logic        [1:0]  i_event_res,
    input  wire logic               i_cfg_valid,
    input  wire logic               i_cfg_ready,
    input  wire logic        [2:0]  i_cfg_index,
    input  wire logic        [15:0] i_cfg_data,
    output int                      o_fail_count,
    output int                      o_pending
);

    t_cfg        cfg;
    logic [9:0]  aim_angle  [FINGERS];
    logic [9:0]  hold_angle [FINGERS];
    logic        oc_locked  [FINGERS];
    logic        grip_locked[FINGERS];
    logic [31:0] rel_start  [FINGERS];
    logic        rel_armed  [FINGERS];

    t_res        awaited_res[$];
    int          errors = 0;

    function automatic logic [9:0] sat_angle(input logic [9:0] a);
        return (a > ANGLE_MAX) ? ANGLE_MAX : a;
    endfunction

    // Applies one request to the finger state and returns the result it must produce.
    function automatic t_res guard_step(input logic [1:0] op, input logic [2:0] f,
                                        input logic [9:0] aim, input logic signed [15:0] amps,
                                        input logic [9:0] pos, input logic [31:0] now);
        t_res        r;
        logic [9:0]  a;
        logic [1:0]  ev;
        int          c;
        logic [31:0] elapsed;
        r = '0;
        r.finger = f;
        ev = EV_NONE;
        if (f >= FINGERS) begin
            return r;
        end
        case (op)
            OP_TARGET: begin
                a = sat_angle(aim);
                if (!oc_locked[f]) begin
                    aim_angle[f] = a;
                end
                if (a > hold_angle[f]) begin
                    grip_locked[f] = 1'b0;
                end
            end
            OP_SAMPLE: begin
                c = amps;
                a = sat_angle(pos);
                if (c > int'(cfg.overcurrent_limit) && !oc_locked[f]) begin
                    oc_locked[f] = 1'b1;
                    hold_angle[f] = a;
                    ev = EV_OVERCURRENT;
                end
                if (cfg.soft_grasp_enable && c > int'(cfg.contact_threshold) &&
                    !grip_locked[f] && !oc_locked[f]) begin
                    grip_locked[f] = 1'b1;
                    hold_angle[f] = a;
                    ev = EV_CONTACT;
                end
                if (oc_locked[f]) begin
                    if (c < int'(cfg.release_current)) begin
                        if (!rel_armed[f]) begin
                            rel_armed[f] = 1'b1;
                            rel_start[f] = now;
                        end
                        elapsed = now - rel_start[f];
                        if (elapsed > {16'd0, cfg.release_time_ms}) begin
                            oc_locked[f] = 1'b0;
                            rel_armed[f] = 1'b0;
                            rel_start[f] = '0;
                            ev = EV_UNLOCK;
                        end
                    end else begin
                        rel_armed[f] = 1'b0;
                        rel_start[f] = '0;
                    end
                end
            end
            OP_TICK: begin
                if (!oc_locked[f] && !grip_locked[f]) begin
                    hold_angle[f] = aim_angle[f];
                end
            end
            default: begin
            end
        endcase
        r.held_angle = hold_angle[f];
        r.locked = oc_locked[f];
        r.contact = grip_locked[f];
        r.event_res = ev;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [2:0] f,
                               input int want, input int got);
        if (want != got) begin
            $display("%0t: finger %0d %s expected %0d, got %0d", $time, f, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_res want;
        if (!i_rst_n) begin
            cfg.overcurrent_limit = RST_OVERCURRENT_LIMIT;
            cfg.contact_threshold = RST_CONTACT_THRESHOLD;
            cfg.soft_grasp_enable = RST_SOFT_GRASP_ENABLE;
            cfg.release_current = RST_RELEASE_CURRENT;
            cfg.release_time_ms = RST_RELEASE_TIME_MS;
            for (int i = 0; i < FINGERS; i++) begin
                aim_angle[i] = ANGLE_MAX;
                hold_angle[i] = ANGLE_MAX;
                oc_locked[i] = 1'b0;
                grip_locked[i] = 1'b0;
                rel_start[i] = '0;
                rel_armed[i] = 1'b0;
            end
            awaited_res.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_OVERCURRENT_LIMIT: cfg.overcurrent_limit = i_cfg_data[14:0];
                    CFG_CONTACT_THRESHOLD: cfg.contact_threshold = i_cfg_data[14:0];
                    CFG_SOFT_GRASP_ENABLE: cfg.soft_grasp_enable = i_cfg_data[0];
                    CFG_RELEASE_CURRENT:   cfg.release_current = i_cfg_data[14:0];
                    CFG_RELEASE_TIME_MS:   cfg.release_time_ms = i_cfg_data;
                    default: begin
                    end
                endcase
            end
            // A result leaving now is always older than a request entering at the same edge.
            if (i_pop && !i_empty) begin
                if (awaited_res.size() == 0) begin
                    $display("%0t: result for finger %0d with none expected, got held %0d",
                             $time, i_finger_out, i_held_angle);
                    errors++;
                end else begin
                    want = awaited_res.pop_front();
                    check_field("finger_out", want.finger, want.finger, i_finger_out);
                    check_field("held_angle", want.finger, want.held_angle, i_held_angle);
                    check_field("overcurrent_locked", want.finger, want.locked,
                                i_overcurrent_locked);
                    check_field("contact_held", want.finger, want.contact, i_contact_held);
                    check_field("event_res", want.finger, want.event_res, i_event_res);
                end
            end
            if (i_push && !i_full) begin
                awaited_res.push_back(guard_step(i_op, i_finger, i_target_angle,
                                                 i_motor_current, i_measured_angle,
                                                 i_timestamp_ms));
            end
        end
        o_pending <= awaited_res.size();
        o_fail_count <= errors;
    end

endmodule

// ===== tb/tb_top.sv =====
// Top of the testbench: clock, reset, request and configuration stimulus, and the verdict.
`timescale 1ns / 100ps

module tb_top;
    import ocg_pkg::*;

    localparam int FINGERS = 6;
    // The block gives this operation code no meaning; it must leave the state untouched.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_BLOCKS = 6;
    localparam int BLOCK_REQUESTS = 100;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;

    logic               push = 1'b0;
    logic               full;
    logic        [1:0]  op = OP_TICK;
    logic        [2:0]  finger = '0;
    logic        [9:0]  target_angle = '0;
    logic signed [15:0] motor_current = '0;
    logic        [9:0]  measured_angle = '0;
    logic        [31:0] timestamp_ms = '0;

    logic               empty;
    logic               pop = 1'b0;
    logic        [2:0]  finger_out;
    logic        [9:0]  held_angle;
    logic               overcurrent_locked;
    logic               contact_held;
    logic        [1:0]  event_res;

    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic        [2:0]  cfg_index = '0;
    logic        [15:0] cfg_data = '0;

    int                 fail_count;
    int                 pending;

    // Chance in a hundred that the sender or the receiver sits out a cycle.
    int                 push_idle_pct = 16;
    int                 pop_idle_pct = 58;

    // The testbench's own copy of the settings, used only to aim the random currents
    // and the clock steps near the thresholds that matter.
    int                 limit_ma = RST_OVERCURRENT_LIMIT;
    int                 contact_ma = RST_CONTACT_THRESHOLD;
    int                 release_ma = RST_RELEASE_CURRENT;
    int                 hold_off_ms = RST_RELEASE_TIME_MS;
    logic        [31:0] now_ms = '0;

    always #2 clk = ~clk;

    finger_overcurrent_grasp_guard #(
        .FINGER_COUNT(FINGERS)
    ) dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .push                (push),
        .full                (full),
        .i_op                (op),
        .i_finger            (finger),
        .i_target_angle      (target_angle),
        .i_motor_current     (motor_current),
        .i_measured_angle    (measured_angle),
        .i_timestamp_ms      (timestamp_ms),
        .empty               (empty),
        .pop                 (pop),
        .o_finger_out        (finger_out),
        .o_held_angle        (held_angle),
        .o_overcurrent_locked(overcurrent_locked),
        .o_contact_held      (contact_held),
        .o_event_res         (event_res),
        .i_cfg_valid         (cfg_valid),
        .o_cfg_ready         (cfg_ready),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data)
    );

    ocg_checker #(
        .FINGERS(FINGERS)
    ) checker_i (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_push              (push),
        .i_full              (full),
        .i_op                (op),
        .i_finger            (finger),
        .i_target_angle      (target_angle),
        .i_motor_current     (motor_current),
        .i_measured_angle    (measured_angle),
        .i_timestamp_ms      (timestamp_ms),
        .i_empty             (empty),
        .i_pop               (pop),
        .i_finger_out        (finger_out),
        .i_held_angle        (held_angle),
        .i_overcurrent_locked(overcurrent_locked),
        .i_contact_held      (contact_held),
        .i_event_res         (event_res),
        .i_cfg_valid         (cfg_valid),
        .i_cfg_ready         (cfg_ready),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data),
        .o_fail_count        (fail_count),
        .o_pending           (pending)
    );

    // The receiver decides at every falling edge whether it takes a result at the next
    // rising edge. With the chance at zero it pops on every cycle.
    always @(negedge clk) begin
        pop <= ($urandom_range(0, 99) >= pop_idle_pct);
    end

    // Offers one request and returns once the rising edge that accepts it has passed.
    // Idle cycles, if any, come before the request is raised, so push never drops and
    // rises within one time step.
    task automatic send_req(input logic [1:0] req_op, input logic [2:0] req_finger,
                            input logic [9:0] req_target, input logic signed [15:0] req_amps,
                            input logic [9:0] req_angle, input logic [31:0] req_ms);
        while ($urandom_range(0, 99) < push_idle_pct) begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push <= 1'b1;
        op <= req_op;
        finger <= req_finger;
        target_angle <= req_target;
        motor_current <= req_amps;
        measured_angle <= req_angle;
        timestamp_ms <= req_ms;
        @(posedge clk);
        while (full) begin
            @(posedge clk);
        end
    endtask

    // Lowers push and waits until every expected result has left the block, plus a few
    // cycles so that nothing is still in flight when the settings change.
    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (3) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Writes all five registers; only called while the block holds no request.
    task automatic set_config(input int lim, input int contact, input int grasp_en,
                              input int rel, input int hold);
        cfg_write(CFG_OVERCURRENT_LIMIT, 16'(lim));
        cfg_write(CFG_CONTACT_THRESHOLD, 16'(contact));
        cfg_write(CFG_SOFT_GRASP_ENABLE, 16'(grasp_en));
        cfg_write(CFG_RELEASE_CURRENT, 16'(rel));
        cfg_write(CFG_RELEASE_TIME_MS, 16'(hold));
        limit_ma = lim;
        contact_ma = contact;
        release_ma = rel;
        hold_off_ms = hold;
    endtask

    // Mostly legal angles, now and then the exact ends, and sometimes values above the
    // maximum that the block must saturate.
    function automatic logic [9:0] pick_angle();
        int r;
        r = $urandom_range(0, 15);
        case (r)
            0:       return 10'd0;
            1:       return ANGLE_MAX;
            2, 3:    return 10'($urandom_range(0, 1023));
            default: return 10'($urandom_range(0, 1000));
        endcase
    endfunction

    // Currents are aimed at the thresholds so that locks, contacts and releases all
    // happen often; a share covers the full signed range.
    function automatic logic signed [15:0] pick_current();
        int r;
        int v;
        r = $urandom_range(0, 11);
        case (r)
            0, 1:    v = limit_ma + $urandom_range(1, 2000);
            2:       v = contact_ma + $urandom_range(0, 4) - 2;
            3:       v = limit_ma + $urandom_range(0, 2) - 1;
            4:       v = release_ma + $urandom_range(0, 2) - 1;
            5, 6, 7: v = release_ma - 1 - $urandom_range(0, 400);
            8:       v = $urandom_range(0, 1) ? 32767 : -32768;
            9:       v = int'($signed(16'($urandom)));
            default: v = $urandom_range(0, 32767);
        endcase
        if (v > 32767) begin
            v = 32767;
        end else if (v < -32768) begin
            v = -32768;
        end
        return 16'(v);
    endfunction

    // Moves the millisecond clock on. Small steps let the release timing run up to its
    // limit over a few samples; rare jumps cover every timestamp bit and the wrap.
    task automatic tick_clock();
        int r;
        r = $urandom_range(0, 99);
        if (r < 2) begin
            now_ms = $urandom;
        end else if (r < 5) begin
            now_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 2 * hold_off_ms + 2));
        end else begin
            now_ms = now_ms + 32'($urandom_range(0, hold_off_ms / 16 + 1));
        end
    endtask

    task automatic random_req();
        int          r;
        logic [1:0]  req_op;
        logic [2:0]  req_finger;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            req_op = OP_TARGET;
        end else if (r < 70) begin
            req_op = OP_SAMPLE;
        end else if (r < 95) begin
            req_op = OP_TICK;
        end else begin
            req_op = OP_UNUSED;
        end
        // One request in twenty names a finger the block does not have.
        if ($urandom_range(0, 19) == 0) begin
            req_finger = 3'($urandom_range(FINGERS, 7));
        end else begin
            req_finger = 3'($urandom_range(0, FINGERS - 1));
        end
        tick_clock();
        send_req(req_op, req_finger, pick_angle(), pick_current(), pick_angle(), now_ms);
    endtask

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed requests under the reset settings, with the first idling pattern.
        // A tick on an idle finger, then a target above the maximum that must saturate.
        send_req(OP_TICK, 3'd0, 10'd0, 16'sd0, 10'd0, 32'd0);
        send_req(OP_TARGET, 3'd0, 10'd1023, 16'sd0, 10'd0, 32'd0);
        // Closing a finger fully and then opening it again without any contact.
        send_req(OP_TARGET, 3'd1, 10'd0, 16'sd0, 10'd0, 32'd0);
        send_req(OP_TICK, 3'd1, 10'd0, 16'sd0, 10'd0, 32'd0);
        send_req(OP_TARGET, 3'd1, 10'd500, 16'sd0, 10'd0, 32'd0);
        // Soft-grasp contact: the tick may not move the finger, a target that does not
        // open past the held angle keeps the contact, one that does clears it.
        send_req(OP_SAMPLE, 3'd2, 10'd0, 16'sd700, 10'd300, 32'd100);
        send_req(OP_TICK, 3'd2, 10'd0, 16'sd0, 10'd0, 32'd0);
        send_req(OP_TARGET, 3'd2, 10'd200, 16'sd0, 10'd0, 32'd0);
        send_req(OP_TARGET, 3'd2, 10'd400, 16'sd0, 10'd0, 32'd0);
        // Overcurrent lock just before the timestamp wraps; a target while locked is
        // dropped. The release timing spans the wrap and lands exactly on the release
        // time, which is not enough; a current at the release level stops the timing.
        send_req(OP_SAMPLE, 3'd3, 10'd0, 16'sd32767, 10'd400, 32'hFFFF_FF00);
        send_req(OP_TARGET, 3'd3, 10'd10, 16'sd0, 10'd0, 32'd0);
        send_req(OP_SAMPLE, 3'd3, 10'd0, 16'sd499, 10'd400, 32'hFFFF_FF00);
        send_req(OP_SAMPLE, 3'd3, 10'd0, 16'sh8000, 10'd400, 32'h0000_02E8);
        send_req(OP_SAMPLE, 3'd3, 10'd0, 16'sd500, 10'd400, 32'h0000_0300);
        // Timing restarts and passes the release time by one millisecond.
        send_req(OP_SAMPLE, 3'd3, 10'd0, 16'sd0, 10'd400, 32'h0000_1000);
        send_req(OP_SAMPLE, 3'd3, 10'd0, 16'sd0, 10'd400, 32'h0000_13E9);
        send_req(OP_TICK, 3'd3, 10'd0, 16'sd0, 10'd0, 32'd0);
        // Exactly at the overcurrent limit only contact locks; one above it locks the
        // finger at a measured angle that has to saturate.
        send_req(OP_SAMPLE, 3'd4, 10'd0, 16'sd1500, 10'd0, 32'd5);
        send_req(OP_SAMPLE, 3'd4, 10'd0, 16'sd1501, 10'd1023, 32'd6);
        // Exactly at the contact threshold nothing happens; one above it does.
        send_req(OP_SAMPLE, 3'd5, 10'd0, 16'sd650, 10'd20, 32'd7);
        send_req(OP_SAMPLE, 3'd5, 10'd0, 16'sd651, 10'd1023, 32'd8);
        // Fingers that do not exist, and the unused operation code.
        send_req(OP_SAMPLE, 3'd6, 10'd0, 16'sd32767, 10'd1023, 32'hFFFF_FFFF);
        send_req(OP_TARGET, 3'd7, 10'd1023, 16'shFFFF, 10'd1023, 32'hFFFF_FFFF);
        send_req(OP_UNUSED, 3'd4, 10'd1023, 16'sd32767, 10'd1023, 32'd9);
        // A timestamp of zero starts the release timing like any other value.
        send_req(OP_SAMPLE, 3'd0, 10'd0, 16'sd2000, 10'd600, 32'd0);
        send_req(OP_SAMPLE, 3'd0, 10'd0, 16'sd0, 10'd600, 32'd0);
        send_req(OP_SAMPLE, 3'd0, 10'd0, 16'shFFFF, 10'd600, 32'd1001);
        drain();

        // Random requests in blocks, each under its own settings. The idling pattern
        // changes every two blocks: slow receiver, then slow sender, then no idling.
        for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
            case (blk)
                0: set_config(1500, 650, 1, 500, 1000);
                1: set_config(0, 0, 0, 0, 0);
                2: set_config(32767, 32767, 1, 32767, 65535);
                4: set_config(800, 300, 1, 700, 50);
                default: set_config($urandom_range(0, 32767), $urandom_range(0, 32767),
                                    $urandom_range(0, 1), $urandom_range(0, 32767),
                                    $urandom_range(0, 65535));
            endcase
            if (blk < 2) begin
                push_idle_pct = 16;
                pop_idle_pct = 58;
            end else if (blk < 4) begin
                push_idle_pct = 58;
                pop_idle_pct = 16;
            end else begin
                push_idle_pct = 0;
                pop_idle_pct = 0;
            end
            now_ms = $urandom;
            repeat (BLOCK_REQUESTS) random_req();
            drain();
        end

        repeat (5) @(posedge clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
